FILE: design/vsar_pkg.sv
// Shared types and constants of the video scroll and address unit.
`timescale 1ns / 1ps
`default_nettype none

package vsar_pkg;

  // Palette geometry
  localparam int PALETTE_ENTRIES_DEF = 32;
  localparam int COLOR_W             = 6;

  // Item kinds, carried on s_tuser
  typedef enum logic [2:0] {
    KIND_REG_WRITE  = 3'd0,
    KIND_REG_READ   = 3'd1,
    KIND_FRAME      = 3'd2,
    KIND_LINE_START = 3'd3,
    KIND_LINE_END   = 3'd4
  } kind_t;

  // External memory request codes, carried on m_tuser
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } mem_req_t;

  // Video register numbers
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Address map and stepping
  localparam logic [13:0] PALETTE_BASE = 14'h3f00;
  localparam logic [14:0] STEP_COLUMN  = 15'd1;
  localparam logic [14:0] STEP_ROW     = 15'd32;
  localparam logic [4:0]  ROW_LAST     = 5'd29;
  localparam logic [4:0]  ROW_MAX      = 5'd31;
  localparam logic [2:0]  FINE_Y_MAX   = 3'd7;

endpackage

`default_nettype wire

FILE: design/vsar_palette.sv
// Palette store with per-entry valid bits; unwritten entries read as zero.
`timescale 1ns / 1ps
`default_nettype none

module vsar_palette #(
  parameter int ENTRIES = vsar_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0]  wr_index,
  input  wire logic [vsar_pkg::COLOR_W-1:0] wr_data,
  input  wire logic [$clog2(ENTRIES)-1:0]  rd_index,
  output logic      [vsar_pkg::COLOR_W-1:0] rd_data
);

  logic [vsar_pkg::COLOR_W-1:0] store [ENTRIES];
  logic [ENTRIES-1:0]           valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_index] <= wr_data;
    end
  end

  assign rd_data = valid[rd_index] ? store[rd_index] : '0;

endmodule

`default_nettype wire

FILE: design/video_scroll_address_registers.sv
// Top level of the video scroll and address unit.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the current and temporary VRAM addresses, fine X, the write toggle,
// increment mode, rendering enables and the palette. Each item on the slave
// stream is a CPU register access or a raster event and gives exactly one
// result item on the master stream, in the cycle after acceptance. An item is
// taken in every cycle: s_tready is low only while the single result register
// holds a result that the sink has not yet taken. Palette accesses through
// register 7 are served inside; other register 7 accesses leave as memory
// requests. Reset clears the palette at once through per-entry valid bits, so
// the block takes items as soon as reset is released.
module video_scroll_address_registers #(
  parameter int PALETTE_ENTRIES = vsar_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // reg_index[2:0], write_data[10:3], zero
  input  wire logic [2:0]  s_tuser,   // kind[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // mem_address[13:0], mem_data[21:14],
                                      // read_data[27:22], current_address[42:28],
                                      // fine_scroll_x[45:43], zero
  output logic [1:0]       m_tuser    // mem_request[1:0]
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);

  // Architectural state
  logic [14:0] cur_addr;
  logic [14:0] tmp_addr;
  logic [2:0]  fine_x;
  logic        write_toggle;
  logic        step_by_row;
  logic        show_bg;
  logic        show_spr;

  logic [14:0] cur_addr_next;
  logic [14:0] tmp_addr_next;
  logic [2:0]  fine_x_next;
  logic        write_toggle_next;
  logic        step_by_row_next;
  logic        show_bg_next;
  logic        show_spr_next;

  // Result register
  vsar_pkg::mem_req_t           out_req;
  logic [13:0]                  out_mem_addr;
  logic [7:0]                   out_mem_data;
  logic [vsar_pkg::COLOR_W-1:0] out_read_data;
  logic [14:0]                  out_cur_addr;
  logic [2:0]                   out_fine_x;

  vsar_pkg::mem_req_t           req_next;
  logic [13:0]                  mem_addr_next;
  logic [7:0]                   mem_data_next;
  logic [vsar_pkg::COLOR_W-1:0] read_data_next;

  logic                         accept;
  vsar_pkg::kind_t              kind;
  logic [2:0]                   reg_index;
  logic [7:0]                   wdata;
  logic [13:0]                  access_addr;
  logic                         in_palette;
  logic [4:0]                   pal_addr;
  logic [IDX_W-1:0]             pal_idx;
  logic                         pal_wr;
  logic [vsar_pkg::COLOR_W-1:0] pal_rd_data;
  logic [14:0]                  stepped_addr;
  logic [14:0]                  vert_addr;
  logic                         drawing;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign kind      = vsar_pkg::kind_t'(s_tuser);
  assign reg_index = s_tdata[2:0];
  assign wdata     = s_tdata[10:3];

  assign access_addr  = cur_addr[13:0];
  assign in_palette   = access_addr >= vsar_pkg::PALETTE_BASE;
  assign stepped_addr = cur_addr + (step_by_row ? vsar_pkg::STEP_ROW : vsar_pkg::STEP_COLUMN);
  assign drawing      = show_bg || show_spr;

  // Backdrop entries mirror: drop bit 4 when the low two bits are zero
  always_comb begin
    pal_addr = access_addr[4:0];
    if (pal_addr[1:0] == 2'b00) begin
      pal_addr[4] = 1'b0;
    end
  end
  assign pal_idx = pal_addr[IDX_W-1:0];

  // Advance fine Y, then the coarse row with its nametable wrap
  always_comb begin
    if (cur_addr[14:12] == vsar_pkg::FINE_Y_MAX) begin
      vert_addr = {3'b000, cur_addr[11:0]};
      if (cur_addr[9:5] == vsar_pkg::ROW_LAST) begin
        vert_addr[9:5] = 5'd0;
        vert_addr[11]  = ~cur_addr[11];
      end else if (cur_addr[9:5] == vsar_pkg::ROW_MAX) begin
        vert_addr[9:5] = 5'd0;
      end else begin
        vert_addr[9:5] = cur_addr[9:5] + 5'd1;
      end
    end else begin
      vert_addr = {cur_addr[14:12] + 3'd1, cur_addr[11:0]};
    end
  end

  always_comb begin
    cur_addr_next     = cur_addr;
    tmp_addr_next     = tmp_addr;
    fine_x_next       = fine_x;
    write_toggle_next = write_toggle;
    step_by_row_next  = step_by_row;
    show_bg_next      = show_bg;
    show_spr_next     = show_spr;
    req_next          = vsar_pkg::REQ_NONE;
    mem_addr_next     = '0;
    mem_data_next     = '0;
    read_data_next    = '0;
    pal_wr            = 1'b0;
    case (kind)
      vsar_pkg::KIND_REG_WRITE: begin
        case (reg_index)
          vsar_pkg::REG_CTRL: begin
            step_by_row_next     = wdata[2];
            tmp_addr_next[11:10] = wdata[1:0];
          end
          vsar_pkg::REG_MASK: begin
            show_spr_next = wdata[4];
            show_bg_next  = wdata[3];
          end
          vsar_pkg::REG_SCROLL: begin
            write_toggle_next = ~write_toggle;
            if (!write_toggle) begin
              tmp_addr_next[4:0] = wdata[7:3];
              fine_x_next        = wdata[2:0];
            end else begin
              tmp_addr_next = {wdata[2:0], tmp_addr[11:10], wdata[7:3], tmp_addr[4:0]};
            end
          end
          vsar_pkg::REG_ADDR: begin
            write_toggle_next = ~write_toggle;
            if (!write_toggle) begin
              tmp_addr_next = {1'b0, wdata[5:0], tmp_addr[7:0]};
            end else begin
              tmp_addr_next = {tmp_addr[14:8], wdata};
              cur_addr_next = {tmp_addr[14:8], wdata};
            end
          end
          vsar_pkg::REG_DATA: begin
            cur_addr_next = stepped_addr;
            if (in_palette) begin
              pal_wr = 1'b1;
            end else begin
              req_next      = vsar_pkg::REQ_WRITE;
              mem_addr_next = access_addr;
              mem_data_next = wdata;
            end
          end
          default: begin
          end
        endcase
      end
      vsar_pkg::KIND_REG_READ: begin
        if (reg_index == vsar_pkg::REG_STATUS) begin
          write_toggle_next = 1'b0;
        end else if (reg_index == vsar_pkg::REG_DATA) begin
          cur_addr_next = stepped_addr;
          if (in_palette) begin
            read_data_next = pal_rd_data;
          end else begin
            req_next      = vsar_pkg::REQ_READ;
            mem_addr_next = access_addr;
          end
        end
      end
      vsar_pkg::KIND_FRAME: begin
        if (drawing) begin
          cur_addr_next = tmp_addr;
        end
      end
      vsar_pkg::KIND_LINE_START: begin
        if (drawing) begin
          cur_addr_next = {cur_addr[14:11], tmp_addr[10], cur_addr[9:5], tmp_addr[4:0]};
        end
      end
      vsar_pkg::KIND_LINE_END: begin
        if (drawing) begin
          cur_addr_next = vert_addr;
        end
      end
      default: begin
      end
    endcase
  end

  vsar_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && pal_wr),
    .wr_index (pal_idx),
    .wr_data  (wdata[vsar_pkg::COLOR_W-1:0]),
    .rd_index (pal_idx),
    .rd_data  (pal_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr     <= '0;
      tmp_addr     <= '0;
      fine_x       <= '0;
      write_toggle <= 1'b0;
      step_by_row  <= 1'b0;
      show_bg      <= 1'b0;
      show_spr     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        cur_addr     <= cur_addr_next;
        tmp_addr     <= tmp_addr_next;
        fine_x       <= fine_x_next;
        write_toggle <= write_toggle_next;
        step_by_row  <= step_by_row_next;
        show_bg      <= show_bg_next;
        show_spr     <= show_spr_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the result until taken; load a fresh one on each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_req       <= req_next;
      out_mem_addr  <= mem_addr_next;
      out_mem_data  <= mem_data_next;
      out_read_data <= read_data_next;
      out_cur_addr  <= cur_addr_next;
      out_fine_x    <= fine_x_next;
    end
  end

  assign m_tuser = out_req;
  assign m_tdata = {2'b00, out_fine_x, out_cur_addr, out_read_data, out_mem_data, out_mem_addr};

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != vsar_pkg::REQ_NONE |-> m_tdata[13:0] < vsar_pkg::PALETTE_BASE)
    else $error("external request aimed at palette range");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != vsar_pkg::REQ_NONE |-> m_tdata[27:22] == '0)
    else $error("palette data on an external request");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != vsar_pkg::REQ_WRITE |-> m_tdata[21:14] == '0)
    else $error("write data without a write request");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the video scroll and address unit.
`timescale 1ns / 1ps

module testbench;

  // Register numbers and item kinds with no name in the package
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] KIND_SPARE   = 3'd7;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] reg_num;
    logic [7:0] data;
  } vram_op_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [13:0] addr;
    logic [7:0]  wdata;
    logic [5:0]  rdata;
    logic [14:0] cur;
    logic [2:0]  fx;
  } vram_result_t;

  typedef struct packed {
    vram_op_t     op;
    logic         typed;
    vram_result_t exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // reg_index[2:0], write_data[10:3], zero
  logic [2:0]  s_tuser;   // kind[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // mem_address[13:0], mem_data[21:14], read_data[27:22],
                          // current_address[42:28], fine_scroll_x[45:43], zero
  logic [1:0]  m_tuser;   // mem_request[1:0]

  // Predictor state
  logic [14:0] vram_cur;
  logic [14:0] vram_tmp;
  logic [2:0]  fine_x_q;
  logic        toggle_q;
  logic        row_step;
  logic        bg_on;
  logic        spr_on;
  logic [5:0]  palette_q [32];

  vram_result_t pending_results [$];
  stim_row_t    dir_table [$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           random_items = 0;

  video_scroll_address_registers u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Entries whose low two bits are zero share a slot with the entry 16 below
  function automatic logic [4:0] palette_slot(input logic [13:0] a);
    return (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
  endfunction

  function automatic logic [13:0] take_data_address();
    logic [13:0] a;
    a = vram_cur[13:0];
    vram_cur = vram_cur + (row_step ? vsar_pkg::STEP_ROW : vsar_pkg::STEP_COLUMN);
    return a;
  endfunction

  function automatic vram_result_t scroll_unit_result(input vram_op_t op);
    vram_result_t r;
    logic [13:0]  a;
    logic         drawing;
    r = '0;
    drawing = bg_on | spr_on;
    case (op.kind)
      vsar_pkg::KIND_REG_WRITE: begin
        case (op.reg_num)
          vsar_pkg::REG_CTRL: begin
            row_step = op.data[2];
            vram_tmp[11:10] = op.data[1:0];
          end
          vsar_pkg::REG_MASK: begin
            spr_on = op.data[4];
            bg_on = op.data[3];
          end
          vsar_pkg::REG_SCROLL: begin
            toggle_q = ~toggle_q;
            if (toggle_q) begin
              vram_tmp[4:0] = op.data[7:3];
              fine_x_q = op.data[2:0];
            end else begin
              vram_tmp[9:5] = op.data[7:3];
              vram_tmp[14:12] = op.data[2:0];
            end
          end
          vsar_pkg::REG_ADDR: begin
            toggle_q = ~toggle_q;
            if (toggle_q) begin
              vram_tmp[14:8] = {1'b0, op.data[5:0]};
            end else begin
              vram_tmp[7:0] = op.data;
              vram_cur = vram_tmp;
            end
          end
          vsar_pkg::REG_DATA: begin
            a = take_data_address();
            if (a < vsar_pkg::PALETTE_BASE) begin
              r.req = vsar_pkg::REQ_WRITE;
              r.addr = a;
              r.wdata = op.data;
            end else begin
              palette_q[palette_slot(a)] = op.data[5:0];
            end
          end
          default: ;
        endcase
      end
      vsar_pkg::KIND_REG_READ: begin
        if (op.reg_num == vsar_pkg::REG_STATUS) begin
          toggle_q = 1'b0;
        end else if (op.reg_num == vsar_pkg::REG_DATA) begin
          a = take_data_address();
          if (a < vsar_pkg::PALETTE_BASE) begin
            r.req = vsar_pkg::REQ_READ;
            r.addr = a;
          end else begin
            r.rdata = palette_q[palette_slot(a)];
          end
        end
      end
      vsar_pkg::KIND_FRAME: begin
        if (drawing) vram_cur = vram_tmp;
      end
      vsar_pkg::KIND_LINE_START: begin
        if (drawing) begin
          vram_cur[10] = vram_tmp[10];
          vram_cur[4:0] = vram_tmp[4:0];
        end
      end
      vsar_pkg::KIND_LINE_END: begin
        if (drawing) begin
          if (vram_cur[14:12] == vsar_pkg::FINE_Y_MAX) begin
            vram_cur[14:12] = 3'd0;
            if (vram_cur[9:5] == vsar_pkg::ROW_LAST) begin
              vram_cur[9:5] = 5'd0;
              vram_cur[11] = ~vram_cur[11];
            end else if (vram_cur[9:5] == vsar_pkg::ROW_MAX) begin
              vram_cur[9:5] = 5'd0;
            end else begin
              vram_cur[9:5] = vram_cur[9:5] + 5'd1;
            end
          end else begin
            vram_cur[14:12] = vram_cur[14:12] + 3'd1;
          end
        end
      end
      default: ;
    endcase
    r.cur = vram_cur;
    r.fx = fine_x_q;
    return r;
  endfunction

  // Present one item, hold it until taken, then queue what it must produce
  task automatic send_item(input vram_op_t op, input logic typed, input vram_result_t exp);
    int           gap;
    vram_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, op.data, op.reg_num};
    s_tuser <= op.kind;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    predicted = scroll_unit_result(op);
    pending_results.push_back(typed ? exp : predicted);
  endtask

  task automatic issue(input logic [2:0] kind, input logic [2:0] reg_num, input logic [7:0] data);
    vram_op_t op;
    op = '{kind, reg_num, data};
    send_item(op, 1'b0, '0);
    random_items++;
  endtask

  // Sink: switch between always ready, random, mostly stalled and alternating patterns
  int sink_mode = 0;
  int sink_left = 0;
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(16, 128);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  task automatic flag_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    vram_result_t got;
    vram_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[13:0], m_tdata[21:14], m_tdata[27:22], m_tdata[42:28],
              m_tdata[45:43]};
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected item, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        flag_field("mem_request", 16'(want.req), 16'(got.req));
        flag_field("mem_address", 16'(want.addr), 16'(got.addr));
        flag_field("mem_data", 16'(want.wdata), 16'(got.wdata));
        flag_field("read_data", 16'(want.rdata), 16'(got.rdata));
        flag_field("current_address", 16'(want.cur), 16'(got.cur));
        flag_field("fine_scroll_x", 16'(want.fx), 16'(got.fx));
      end
    end
  end

  initial begin : stimulus
    int          k;
    int          n;
    logic [13:0] target;
    logic [7:0]  b;
    logic [4:0]  row;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    m_tready <= 1'b0;

    vram_cur = '0;
    vram_tmp = '0;
    fine_x_q = '0;
    toggle_q = 1'b0;
    row_step = 1'b0;
    bg_on = 1'b0;
    spr_on = 1'b0;
    for (k = 0; k < 32; k++) palette_q[k] = '0;

    // Address and scroll setup, palette mirroring, ignored registers, rendering off,
    // then scroll at all ones so the raster steps and the data port wrap
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_READ, vsar_pkg::REG_DATA, 8'h00}, 1'b1,
      '{vsar_pkg::REQ_READ, 14'h0000, 8'h00, 6'h00, 15'h0001, 3'd0}});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_SCROLL, 8'hff}, 1'b1,
      '{vsar_pkg::REQ_NONE, 14'h0000, 8'h00, 6'h00, 15'h0001, 3'd7}});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_SCROLL, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_ADDR, 8'hff}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_ADDR, 8'h00}, 1'b1,
      '{vsar_pkg::REQ_NONE, 14'h0000, 8'h00, 6'h00, 15'h3f00, 3'd7}});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_DATA, 8'hff}, 1'b1,
      '{vsar_pkg::REQ_NONE, 14'h0000, 8'h00, 6'h00, 15'h3f01, 3'd7}});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_CTRL, 8'h04}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_ADDR, 8'h3f}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_ADDR, 8'h10}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_READ, vsar_pkg::REG_DATA, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_READ, vsar_pkg::REG_STATUS, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_STATUS, 8'ha5}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, REG_OAM_ADDR, 8'h5a}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_READ, vsar_pkg::REG_SCROLL, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{KIND_SPARE, vsar_pkg::REG_DATA, 8'hff}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_MASK, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_FRAME, vsar_pkg::REG_CTRL, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_LINE_END, vsar_pkg::REG_CTRL, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_SCROLL, 8'hff}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_SCROLL, 8'hff}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_CTRL, 8'h07}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_MASK, 8'h18}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_FRAME, vsar_pkg::REG_CTRL, 8'h00}, 1'b1,
      '{vsar_pkg::REQ_NONE, 14'h0000, 8'h00, 6'h00, 15'h7fff, 3'd7}});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_LINE_END, vsar_pkg::REG_CTRL, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_FRAME, vsar_pkg::REG_CTRL, 8'h00}, 1'b0, '0});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_REG_READ, vsar_pkg::REG_DATA, 8'h00}, 1'b1,
      '{vsar_pkg::REQ_NONE, 14'h0000, 8'h00, 6'h00, 15'h001f, 3'd7}});
    dir_table.push_back(stim_row_t'{
      '{vsar_pkg::KIND_LINE_START, vsar_pkg::REG_CTRL, 8'h00}, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_item(dir_table[i].op, dir_table[i].typed, dir_table[i].exp);

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          // Point the address at VRAM or the palette, then stream through the data port
          target = ($urandom_range(0, 1) == 1) ? {6'h3f, 8'($urandom)} : 14'($urandom);
          issue(vsar_pkg::KIND_REG_READ, vsar_pkg::REG_STATUS, 8'($urandom));
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_ADDR, {2'($urandom), target[13:8]});
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_ADDR, target[7:0]);
          n = $urandom_range(1, 10);
          repeat (n) begin
            issue(($urandom_range(0, 1) == 1) ? vsar_pkg::KIND_REG_READ
                                               : vsar_pkg::KIND_REG_WRITE,
                  vsar_pkg::REG_DATA, 8'($urandom));
          end
        end
        3, 4: begin
          // Favor the rows where the vertical step wraps
          row = ($urandom_range(0, 2) == 0) ?
                (($urandom_range(0, 1) == 1) ? vsar_pkg::ROW_LAST : vsar_pkg::ROW_MAX) :
                5'($urandom);
          issue(vsar_pkg::KIND_REG_READ, vsar_pkg::REG_STATUS, 8'($urandom));
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_SCROLL, 8'($urandom));
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_SCROLL, {row, 3'($urandom)});
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_CTRL, 8'($urandom));
          b = 8'($urandom);
          if ($urandom_range(0, 3) != 0) b[3] = 1'b1;
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_MASK, b);
        end
        5, 6, 7: begin
          issue(vsar_pkg::KIND_FRAME, 3'($urandom), 8'($urandom));
          n = $urandom_range(1, 24);
          repeat (n) begin
            issue(vsar_pkg::KIND_LINE_START, 3'($urandom), 8'($urandom));
            if ($urandom_range(0, 3) == 0) begin
              issue(($urandom_range(0, 1) == 1) ? vsar_pkg::KIND_REG_READ
                                                 : vsar_pkg::KIND_REG_WRITE,
                    vsar_pkg::REG_DATA, 8'($urandom));
            end
            issue(vsar_pkg::KIND_LINE_END, 3'($urandom), 8'($urandom));
          end
        end
        8: begin
          b = 8'($urandom);
          if ($urandom_range(0, 2) != 0) b[4] = 1'b1;
          issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_MASK, b);
        end
        9: issue(vsar_pkg::KIND_REG_WRITE, vsar_pkg::REG_CTRL, 8'($urandom));
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) issue(3'($urandom), 3'($urandom), 8'($urandom));
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
